// ===== sv/ece_pkg.sv =====
// Shared types for the easing curve evaluator.
package ece_pkg;

    // Curve selector carried on the input tuser.
    typedef enum logic [2:0] {
        OP_LINEAR     = 3'd0,
        OP_IN         = 3'd1,
        OP_OUT        = 3'd2,
        OP_IN_OUT     = 3'd3,
        OP_SMOOTH     = 3'd4,
        OP_BACK       = 3'd5,
        OP_BOUNCE     = 3'd6,
        OP_LINEAR_ALT = 3'd7
    } ease_op_t;

    // Segment of the bounce curve that t falls in.
    typedef enum logic [1:0] {
        SEG_FIRST  = 2'd0,
        SEG_SECOND = 2'd1,
        SEG_THIRD  = 2'd2,
        SEG_FOURTH = 2'd3
    } bounce_seg_t;

endpackage

// ===== sv/easing_curve_eval.sv =====
// Easing curve evaluator: five-stage pipeline from progress to eased value.
//
//  Channel | Signals                             | Contents
//  --------+-------------------------------------+------------------------------------
//  input   | s_tvalid s_tready s_tuser s_tdata   | tuser: op; tdata: progress (Q2.F)
//  output  | m_tvalid m_tready m_tdata           | tdata: eased (unsigned Q1.F)
//
// One beat is accepted per cycle while no back-pressure reaches the input; a result
// passes through four compute stages, the first loaded at the edge that takes its
// beat, then the output register, a depth set by the chain of three dependent
// multiplies of the ease-out-back curve.
// Each stage has its own valid bit and loads whenever it is empty or the stage
// after it moves, so a stall at the output fills bubbles before pushing back.
// Reset clears the valid bits only; the data registers need none.
module easing_curve_eval #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [2:0]                              s_tuser,  // [2:0] op
    input  logic [((FRAC_BITS + 2 + 7) / 8) * 8 - 1:0] s_tdata,  // progress, zero pad above
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [((FRAC_BITS + 1 + 7) / 8) * 8 - 1:0] m_tdata   // eased, zero pad above
);

    localparam int F      = FRAC_BITS;
    localparam int OUT_DW = ((F + 1 + 7) / 8) * 8;
    localparam int D_W    = F + 6;
    localparam int R_W    = F + 4;

    localparam longint ONE_L = 64'sd1 <<< F;
    localparam longint C1_L  = (64'sd170158 * ONE_L + 64'sd50000) / 64'sd100000;

    localparam logic [F:0]     ONE     = (F + 1)'(ONE_L);
    localparam logic [F+1:0]   THREE   = (F + 2)'(3 * ONE_L);
    localparam logic [F:0]     C1      = (F + 1)'(C1_L);
    localparam logic [F+1:0]   C3      = (F + 2)'(C1_L + ONE_L);
    localparam logic [D_W-1:0] K4      = D_W'(4 * ONE_L);
    localparam logic [D_W-1:0] K6      = D_W'(6 * ONE_L);
    localparam logic [D_W-1:0] K8      = D_W'(8 * ONE_L);
    localparam logic [D_W-1:0] K9      = D_W'(9 * ONE_L);
    localparam logic [D_W-1:0] K10     = D_W'(10 * ONE_L);
    localparam logic [D_W-1:0] K21     = D_W'(21 * ONE_L);
    localparam logic [F:0]     B_OFS1  = (F + 1)'((3 * ONE_L) / 4);
    localparam logic [F:0]     B_OFS2  = (F + 1)'((15 * ONE_L) / 16);
    localparam logic [F:0]     B_OFS3  = (F + 1)'((63 * ONE_L) / 64);
    localparam logic [F:0]     OUT_MAX = '1;

    // Pipeline enables: a stage loads when it is empty or its successor loads.
    logic v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic en1, en2, en3, en4, eno;

    assign eno      = !vo_reg || m_tready;
    assign en4      = !v4_reg || eno;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign m_tvalid = vo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (eno) vo_reg <= v4_reg;
        end
    end

    // Stage 1: clamp progress to 0..ONE and form u, 3-2t and 11t.
    logic [F+1:0]         progress;
    logic [F:0]           t_clamp;
    ece_pkg::ease_op_t    op1_reg;
    logic [F:0]           t1_reg, u1_reg;
    logic [F+1:0]         s1_reg;
    logic [F+3:0]         t11_1_reg;

    assign progress = s_tdata[F+1:0];

    always_comb
    begin
        priority if (progress[F+1])
            t_clamp = '0;
        else if (progress[F:0] > ONE)
            t_clamp = ONE;
        else
            t_clamp = progress[F:0];
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            op1_reg   <= ece_pkg::ease_op_t'(s_tuser);
            t1_reg    <= t_clamp;
            u1_reg    <= ONE - t_clamp;
            s1_reg    <= THREE - {t_clamp, 1'b0};
            t11_1_reg <= ({3'b000, t_clamp} << 3) + ({3'b000, t_clamp} << 1)
                         + {3'b000, t_clamp};
        end
    end

    // Stage 2: t*t, u*u and the bounce segment with its offset magnitude.
    logic [2*F+1:0]            tt_full, uu_full;
    logic [D_W-1:0]            t11_d, bdiff;
    logic [F+1:0]              bmag;
    ece_pkg::bounce_seg_t      bseg;
    ece_pkg::ease_op_t         op2_reg;
    logic [F:0]                t2_reg, u2_reg, tt2_reg, uu2_reg;
    logic [F+1:0]              s2_reg, bmag2_reg;
    ece_pkg::bounce_seg_t      bseg2_reg;

    assign tt_full = t1_reg * t1_reg;
    assign uu_full = u1_reg * u1_reg;
    assign t11_d   = D_W'(t11_1_reg);

    always_comb
    begin
        priority if (t11_d < K4)
        begin
            bseg  = ece_pkg::SEG_FIRST;
            bdiff = t11_d;
        end
        else if (t11_d < K8)
        begin
            bseg  = ece_pkg::SEG_SECOND;
            bdiff = t11_d - K6;
        end
        else if (t11_d < K10)
        begin
            bseg  = ece_pkg::SEG_THIRD;
            bdiff = t11_d - K9;
        end
        else
        begin
            bseg  = ece_pkg::SEG_FOURTH;
            bdiff = (t11_d << 1) - K21;
        end
    end

    // Offsets stay below 4*ONE in magnitude.
    always_comb
    begin
        if (bdiff[D_W-1])
            bmag = (F + 2)'(-bdiff);
        else
            bmag = bdiff[F+1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            op2_reg   <= op1_reg;
            t2_reg    <= t1_reg;
            u2_reg    <= u1_reg;
            s2_reg    <= s1_reg;
            tt2_reg   <= tt_full[2*F:F];
            uu2_reg   <= uu_full[2*F:F];
            bseg2_reg <= bseg;
            bmag2_reg <= bmag;
        end
    end

    // Stage 3: smoothstep product, C1*u^2, u^3 and the bounce square.
    logic [2*F+2:0]            smooth_full;
    logic [2*F+1:0]            back1_full, uuu_full;
    logic [2*F+3:0]            bsq_full, bsq_shift;
    ece_pkg::ease_op_t         op3_reg;
    logic [F:0]                t3_reg, tt3_reg, uu3_reg, uuu3_reg, smooth3_reg, bsq3_reg;
    logic [F+1:0]              back1_3_reg;
    ece_pkg::bounce_seg_t      bseg3_reg;

    assign smooth_full = tt2_reg * s2_reg;
    assign back1_full  = C1 * uu2_reg;
    assign uuu_full    = uu2_reg * u2_reg;
    assign bsq_full    = bmag2_reg * bmag2_reg;
    assign bsq_shift   = (bseg2_reg == ece_pkg::SEG_FOURTH) ? (bsq_full >> (F + 6))
                                                            : (bsq_full >> (F + 4));

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            op3_reg     <= op2_reg;
            t3_reg      <= t2_reg;
            tt3_reg     <= tt2_reg;
            uu3_reg     <= uu2_reg;
            uuu3_reg    <= uuu_full[2*F:F];
            smooth3_reg <= smooth_full[2*F:F];
            back1_3_reg <= back1_full[2*F+1:F];
            bsq3_reg    <= bsq_shift[F:0];
            bseg3_reg   <= bseg2_reg;
        end
    end

    // Stage 4: C3*u^3 and the bounce segment constant.
    logic [2*F+2:0]            back3_full;
    logic [F:0]                bofs;
    ece_pkg::ease_op_t         op4_reg;
    logic [F:0]                t4_reg, tt4_reg, uu4_reg, smooth4_reg, bounce4_reg;
    logic [F+1:0]              back1_4_reg;
    logic [F+2:0]              back3_4_reg;

    assign back3_full = C3 * uuu3_reg;

    always_comb
    begin
        unique case (bseg3_reg)
            ece_pkg::SEG_FIRST:  bofs = '0;
            ece_pkg::SEG_SECOND: bofs = B_OFS1;
            ece_pkg::SEG_THIRD:  bofs = B_OFS2;
            ece_pkg::SEG_FOURTH: bofs = B_OFS3;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            op4_reg     <= op3_reg;
            t4_reg      <= t3_reg;
            tt4_reg     <= tt3_reg;
            uu4_reg     <= uu3_reg;
            smooth4_reg <= smooth3_reg;
            back1_4_reg <= back1_3_reg;
            back3_4_reg <= back3_full[2*F+2:F];
            bounce4_reg <= bsq3_reg + bofs;
        end
    end

    // Output stage: pick the curve and saturate to 0..2^(F+1)-1.
    logic [R_W-1:0] r_val;
    logic [F:0]     eased_next;
    logic [F:0]     eased_reg;

    always_comb
    begin
        unique case (op4_reg)
            ece_pkg::OP_LINEAR,
            ece_pkg::OP_LINEAR_ALT: r_val = R_W'(t4_reg);
            ece_pkg::OP_IN:         r_val = R_W'(tt4_reg);
            ece_pkg::OP_OUT:        r_val = R_W'(ONE) - R_W'(uu4_reg);
            ece_pkg::OP_IN_OUT:
            begin
                if (t4_reg < (ONE >> 1))
                    r_val = R_W'(tt4_reg) << 1;
                else
                    r_val = R_W'(ONE) - (R_W'(uu4_reg) << 1);
            end
            ece_pkg::OP_SMOOTH:     r_val = R_W'(smooth4_reg);
            ece_pkg::OP_BACK:       r_val = R_W'(ONE) + R_W'(back1_4_reg)
                                            - R_W'(back3_4_reg);
            ece_pkg::OP_BOUNCE:     r_val = R_W'(bounce4_reg);
        endcase
    end

    always_comb
    begin
        priority if (r_val[R_W-1])
            eased_next = '0;
        else if (r_val[R_W-2:F+1] != '0)
            eased_next = OUT_MAX;
        else
            eased_next = r_val[F:0];
    end

    always_ff @(posedge clk)
    begin
        if (eno)
            eased_reg <= eased_next;
    end

    assign m_tdata = OUT_DW'(eased_reg);

    // Input back-pressure only when every stage holds a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && v4_reg && vo_reg))
        else $error("input stalled while a pipeline stage was empty");

    // A beat in the last compute stage survives an output stall.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && vo_reg && !m_tready) |=> v4_reg)
        else $error("beat dropped from stage four during output stall");

    // A linear beat moving to the output carries its clamped progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && eno && (op4_reg == ece_pkg::OP_LINEAR || op4_reg == ece_pkg::OP_LINEAR_ALT))
        |=> (eased_reg == $past(t4_reg)))
        else $error("linear curve result differs from clamped progress");

endmodule
